/* src/iasc_pkg.sv */
// Shared constants, codes and item types for the sigma-clipped image averaging block.
// Depends on nothing; the other files of the block, but for the stream interface, refer to it by scoped names.
package iasc_pkg;

  // Sum store geometry and display range.
  localparam int unsigned MAX_PIXELS = 4096;
  localparam int unsigned IDX_W      = $clog2(MAX_PIXELS);
  localparam int unsigned NPIX_W     = IDX_W + 1;
  localparam int unsigned SUM_W      = 48;
  localparam logic [6:0]  DISPLAY_TOP = 7'd127;

  // Largest clip offset, as in the arithmetic definition.
  localparam logic [63:0] OFF_MAX = 64'h1000_0000_0000_0000;

  // Item actions.
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_ACCUM   = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BLANK     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_NO_IMAGES = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_UPPER_FACTOR  = 3'd2;
  localparam logic [2:0] REG_LOWER_FACTOR  = 3'd3;
  localparam logic [2:0] REG_DISPLAY_FLOOR = 3'd4;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic         start;
    arith_op_e    op;
    logic [127:0] a;
    logic [63:0]  b;
  } arith_req_t;

  typedef struct packed {
    logic [NPIX_W-1:0] npix;
    logic [15:0]       upper_k;
    logic [15:0]       lower_k;
    logic [6:0]        steps;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  pixel_index;
    logic signed [31:0] sample;
    logic              end_of_image;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] average_value;
    logic [6:0]         display_code;
    logic [15:0]        image_count;
  } out_item_t;

endpackage

/* src/iasc_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
// The payload type is set where the channel is instantiated (usually an iasc_pkg item type).
interface iasc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/iasc_arith.sv */
// Shared multi-cycle arithmetic unit: 64x64 multiply, 128/64 divide and 128-bit square root.
// Depends on iasc_pkg for the request struct and operation codes.
module iasc_arith (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  iasc_pkg::arith_req_t    req_i,
  output logic                    busy_o,
  output logic [127:0]            result_o
);

  logic                  busy_q, busy_d;
  iasc_pkg::arith_op_e   op_q, op_d;
  logic [6:0]            step_q, step_d;
  logic [127:0]          opa_q, opa_d;
  logic [63:0]           opb_q, opb_d;
  logic [127:0]          acc_q, acc_d;
  logic [67:0]           rem_q, rem_d;
  logic [63:0]           pp_q, pp_d;
  logic [1:0]            ppsh_q, ppsh_d;

  logic [31:0]  mul_x, mul_y;
  logic [127:0] pp_ext;
  logic [64:0]  div_sh;
  logic         div_ge;
  logic [67:0]  sq_sh, sq_trial;
  logic         sq_ge;
  logic         last;

  // Partial products of the multiply: low/high halves chosen by the step bits.
  assign mul_x = step_q[0] ? opa_q[63:32] : opa_q[31:0];
  assign mul_y = step_q[1] ? opb_q[63:32] : opb_q[31:0];

  always_comb begin
    unique case (ppsh_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
      2'd2:    pp_ext = {pp_q, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // Restoring divide: one quotient bit per cycle, quotient shifts into opa.
  assign div_sh = {rem_q[63:0], opa_q[127]};
  assign div_ge = div_sh >= {1'b0, opb_q};

  // Digit-by-digit square root: two radicand bits per cycle, root builds in acc.
  assign sq_sh    = {rem_q[65:0], opa_q[127:126]};
  assign sq_trial = {2'b00, acc_q[63:0], 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    unique case (op_q)
      iasc_pkg::OP_MUL:  last = (step_q == 7'd4);
      iasc_pkg::OP_DIV:  last = (step_q == 7'd127);
      iasc_pkg::OP_SQRT: last = (step_q == 7'd63);
      default:           last = 1'b1;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    step_d = step_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    pp_d   = 64'(mul_x) * 64'(mul_y);
    ppsh_d = {step_q[0] & step_q[1], step_q[0] ^ step_q[1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      step_d = '0;
      opa_d  = req_i.a;
      opb_d  = req_i.b;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      step_d = step_q + 7'd1;
      if (last) begin
        busy_d = 1'b0;
      end
      unique case (op_q)
        iasc_pkg::OP_MUL: begin
          if (step_q != 7'd0) begin
            acc_d = acc_q + pp_ext;
          end
        end
        iasc_pkg::OP_DIV: begin
          rem_d = div_ge ? {3'd0, div_sh - {1'b0, opb_q}} : {3'd0, div_sh};
          opa_d = {opa_q[126:0], div_ge};
        end
        iasc_pkg::OP_SQRT: begin
          rem_d = sq_ge ? (sq_sh - sq_trial) : sq_sh;
          acc_d = {64'd0, acc_q[62:0], sq_ge};
          opa_d = {opa_q[125:0], 2'b00};
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= iasc_pkg::OP_MUL;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    pp_q   <= pp_d;
    ppsh_q <= ppsh_d;
  end

  assign busy_o   = busy_q;
  assign result_o = (op_q == iasc_pkg::OP_DIV) ? opa_q : acc_q;

endmodule

/* src/iasc_cfg.sv */
// Configuration registers behind an APB-style port, and the settings derived from them.
// Depends on iasc_pkg for register indexes and the settings struct.
module iasc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output iasc_pkg::cfg_t      cfg_o
);

  logic [6:0]  width_q, height_q, floor_q;
  logic [15:0] upper_q, lower_q;
  logic        wr;
  logic [2:0]  reg_idx;
  logic [6:0]  w_eff, h_eff;
  logic [13:0] npix_full;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      upper_q  <= 16'd768;
      lower_q  <= 16'd768;
      floor_q  <= 7'd0;
    end else if (wr) begin
      unique case (reg_idx)
        iasc_pkg::REG_IMAGE_WIDTH:   width_q  <= pwdata[6:0];
        iasc_pkg::REG_IMAGE_HEIGHT:  height_q <= pwdata[6:0];
        iasc_pkg::REG_UPPER_FACTOR:  upper_q  <= pwdata[15:0];
        iasc_pkg::REG_LOWER_FACTOR:  lower_q  <= pwdata[15:0];
        iasc_pkg::REG_DISPLAY_FLOOR: floor_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      iasc_pkg::REG_IMAGE_WIDTH:   prdata = {25'd0, width_q};
      iasc_pkg::REG_IMAGE_HEIGHT:  prdata = {25'd0, height_q};
      iasc_pkg::REG_UPPER_FACTOR:  prdata = {16'd0, upper_q};
      iasc_pkg::REG_LOWER_FACTOR:  prdata = {16'd0, lower_q};
      iasc_pkg::REG_DISPLAY_FLOOR: prdata = {25'd0, floor_q};
      default:                     prdata = '0;
    endcase
  end

  // Sides are taken as at least 1 and at most 64 pixels.
  assign w_eff = (width_q == 7'd0) ? 7'd1 : ((width_q > 7'd64) ? 7'd64 : width_q);
  assign h_eff = (height_q == 7'd0) ? 7'd1 : ((height_q > 7'd64) ? 7'd64 : height_q);
  assign npix_full = 14'(w_eff) * 14'(h_eff);

  assign cfg_o.npix    = npix_full[iasc_pkg::NPIX_W-1:0];
  assign cfg_o.upper_k = upper_q;
  assign cfg_o.lower_k = lower_q;
  assign cfg_o.steps   = iasc_pkg::DISPLAY_TOP - floor_q;

endmodule

/* src/image_average_sigma_clip_scale_core.sv */
// Top level of the sigma-clipped image averaging and contrast stretch block.
// Depends on iasc_pkg, iasc_stream_if, iasc_cfg and iasc_arith.

// The block sums pixels of a stack of equal-size images into a 4096 x 48-bit store, then on
// request derives min, max, mean and sigma, clips to mean - k_low*sigma .. mean + k_high*sigma
// and maps the clipped range onto display codes. One item is taken at a time: in_i.ready is
// high only while the sequencer is idle, and a result waits in an output register so the next
// item can be taken before the previous result is consumed. An accumulate item reads the store
// entry and then writes it back; a restart is done as it is taken. A read item is dominated by
// two passes through the shared bit-serial divider. A compute item walks over the store (each
// square goes through the shared 32x32 multiplier in four partial products) and then runs the
// three wide divisions, the 64-step square root, one wide and four small multiplies. No clearing
// pass is needed after reset or restart: the first image writes every entry it covers.
module image_average_sigma_clip_scale_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  iasc_stream_if.sink         in_i,
  iasc_stream_if.source       out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = iasc_pkg::IDX_W;
  localparam int unsigned NW = iasc_pkg::NPIX_W;
  localparam int unsigned SW = iasc_pkg::SUM_W;

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ACC   = 5'd1;
  localparam logic [4:0] S_WRD   = 5'd2;
  localparam logic [4:0] S_WSQ   = 5'd3;
  localparam logic [4:0] S_WADD  = 5'd4;
  localparam logic [4:0] S_WEND  = 5'd5;
  localparam logic [4:0] S_MEAN  = 5'd6;
  localparam logic [4:0] S_D1    = 5'd7;
  localparam logic [4:0] S_D2    = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_OFF1  = 5'd10;
  localparam logic [4:0] S_OFF2  = 5'd11;
  localparam logic [4:0] S_OFF3  = 5'd12;
  localparam logic [4:0] S_OFF4  = 5'd13;
  localparam logic [4:0] S_OFFL  = 5'd14;
  localparam logic [4:0] S_CLIP  = 5'd15;
  localparam logic [4:0] S_SPAN  = 5'd16;
  localparam logic [4:0] S_RCLIP = 5'd17;
  localparam logic [4:0] S_RAVG  = 5'd18;
  localparam logic [4:0] S_RNUM  = 5'd19;
  localparam logic [4:0] S_RCODE = 5'd20;
  localparam logic [4:0] S_WAIT  = 5'd21;
  localparam logic [4:0] S_EMIT  = 5'd22;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] avg;
    logic [6:0]  code;
  } res_t;

  iasc_pkg::cfg_t       cfg;
  iasc_pkg::arith_req_t ar_req;
  logic                 ar_busy;
  logic [127:0]         ar_res;

  iasc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iasc_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ar_req),
    .busy_o   (ar_busy),
    .result_o (ar_res)
  );

  // Control state.
  logic [4:0]   st_q, st_d, ret_q, ret_d;
  logic [15:0]  images_q, images_d;
  logic         rdy_q, rdy_d;
  logic         out_vld_q, out_vld_d;
  // Statistics kept between items.
  logic [SW-1:0] clip_hi_q, clip_hi_d, clip_lo_q, clip_lo_d;
  logic [6:0]    steps_q, steps_d;
  logic [SW:0]   span_q, span_d;
  // Working registers of one item.
  logic [IW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [31:0]   samp_q, samp_d;
  logic          first_q, first_d;
  logic [SW-1:0] mn_q, mn_d, mx_q, mx_d, b_q, b_d;
  logic [63:0]   s1_q, s1_d, mean_q, mean_d, sigma_q, sigma_d, p_q, p_d;
  logic [63:0]   offu_q, offu_d, offl_q, offl_d;
  logic [127:0]  s2_q, s2_d;
  res_t          res_q, res_d;
  iasc_pkg::out_item_t out_q, out_d;

  // Sum store: one read and one write port, read data registered.
  logic [SW-1:0] store_q [iasc_pkg::MAX_PIXELS];
  logic [SW-1:0] rd_q;
  logic [IW-1:0] raddr;
  logic          re, we;
  logic [SW-1:0] wdata;

  logic          accept, in_idx_ok;
  logic [SW:0]   acc_sum;
  logic [SW-1:0] ax, bcl1, bcl, abs_bcl;
  logic [63:0]   as1, sig, num64;
  logic [SW:0]   dif;
  logic [31:0]   avg_sat;
  logic signed [63:0] hi64, lo64, mx64, mn64;

  function automatic logic [63:0] sat_off(input logic [63:0] p, input logic [63:0] r);
    logic [63:0] s;
    s = p + {8'd0, r[63:8]};
    return (s > iasc_pkg::OFF_MAX) ? iasc_pkg::OFF_MAX : s;
  endfunction

  assign in_i.ready = (st_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_idx_ok  = {1'b0, in_i.payload.pixel_index} < cfg.npix;

  // The store is read at the item's index when an item is taken, and at the walk counter.
  assign raddr = (st_q == S_IDLE) ? in_i.payload.pixel_index : cnt_q;
  assign re    = accept || (st_q == S_WRD);
  assign we    = (st_q == S_ACC);

  // Accumulate: the first image overwrites, later images add; the sum saturates to 48 bits.
  assign acc_sum = {{(SW-31){samp_q[31]}}, samp_q} +
                   (first_q ? '0 : {rd_q[SW-1], rd_q});
  assign wdata = (acc_sum[SW] != acc_sum[SW-1]) ?
                 (acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}) :
                 acc_sum[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[idx_q] <= wdata;
    end
    if (re) begin
      rd_q <= store_q[raddr];
    end
  end

  // Magnitudes for the unsigned arithmetic unit.
  assign ax  = rd_q[SW-1] ? (~rd_q + 1'b1) : rd_q;
  assign as1 = s1_q[63] ? (~s1_q + 64'd1) : s1_q;

  // Sigma is zero for a single pixel.
  assign sig = (cfg.npix < NW'(2)) ? 64'd0 : ar_res[63:0];

  // Read: clamp the stored sum into the clip window.
  assign bcl1    = ($signed(rd_q) > $signed(clip_hi_q)) ? clip_hi_q : rd_q;
  assign bcl     = ($signed(bcl1) < $signed(clip_lo_q)) ? clip_lo_q : bcl1;
  assign abs_bcl = bcl[SW-1] ? (~bcl + 1'b1) : bcl;

  // Quotient magnitude back to a signed average, saturated to 32 bits.
  always_comb begin
    if (!b_q[SW-1]) begin
      avg_sat = (ar_res[63:0] > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : ar_res[31:0];
    end else begin
      avg_sat = (ar_res[63:0] > 64'h0000_0000_8000_0000) ? 32'h8000_0000 :
                (~ar_res[31:0] + 32'd1);
    end
  end

  assign dif   = {b_q[SW-1], b_q} - {clip_lo_q[SW-1], clip_lo_q};
  assign num64 = {ar_res[62:0], 1'b0} + {{(63-SW){1'b0}}, span_q};

  // Clip window from the mean and the two sigma offsets.
  assign hi64 = $signed(mean_q) + $signed(offu_q);
  assign lo64 = $signed(mean_q) - $signed(offl_q);
  assign mx64 = {{(64-SW){mx_q[SW-1]}}, mx_q};
  assign mn64 = {{(64-SW){mn_q[SW-1]}}, mn_q};

  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    images_d  = images_q;
    rdy_d     = rdy_q;
    clip_hi_d = clip_hi_q;
    clip_lo_d = clip_lo_q;
    steps_d   = steps_q;
    span_d    = span_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    samp_d    = samp_q;
    first_d   = first_q;
    mn_d      = mn_q;
    mx_d      = mx_q;
    b_d       = b_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    mean_d    = mean_q;
    sigma_d   = sigma_q;
    p_d       = p_q;
    offu_d    = offu_q;
    offl_d    = offl_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_d     = out_q;
    ar_req    = '0;

    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          idx_d  = in_i.payload.pixel_index;
          samp_d = in_i.payload.sample;
          res_d  = '0;
          cnt_d  = '0;
          unique case (in_i.payload.action)
            iasc_pkg::ACT_RESTART: begin
              images_d  = '0;
              rdy_d     = 1'b0;
              clip_hi_d = '0;
              clip_lo_d = '0;
              steps_d   = '0;
              span_d    = '0;
            end
            iasc_pkg::ACT_ACCUM: begin
              rdy_d   = 1'b0;
              first_d = (images_q == 16'd0);
              if (in_i.payload.end_of_image && (images_q != 16'hFFFF)) begin
                images_d = images_q + 16'd1;
              end
              if (in_idx_ok) begin
                st_d = S_ACC;
              end
            end
            iasc_pkg::ACT_COMPUTE: begin
              rdy_d = 1'b0;
              if (images_q == 16'd0) begin
                res_d.status = iasc_pkg::ST_NO_IMAGES;
                st_d         = S_EMIT;
              end else begin
                s1_d = '0;
                s2_d = '0;
                st_d = S_WRD;
              end
            end
            iasc_pkg::ACT_READ: begin
              if (!rdy_q) begin
                res_d.status = (images_q == 16'd0) ? iasc_pkg::ST_NO_IMAGES :
                                                     iasc_pkg::ST_NOT_READY;
                st_d = S_EMIT;
              end else if (!in_idx_ok) begin
                st_d = S_EMIT;
              end else begin
                st_d = S_RCLIP;
              end
            end
          endcase
        end
      end
      S_ACC: begin
        st_d = S_IDLE;
      end
      // Walk over the store: one entry per pass, square through the shared multiplier.
      S_WRD: begin
        st_d = S_WSQ;
      end
      S_WSQ: begin
        if (cnt_q == '0) begin
          mn_d = rd_q;
          mx_d = rd_q;
        end else begin
          if ($signed(rd_q) < $signed(mn_q)) mn_d = rd_q;
          if ($signed(rd_q) > $signed(mx_q)) mx_d = rd_q;
        end
        s1_d         = s1_q + {{(64-SW){rd_q[SW-1]}}, rd_q};
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_MUL;
        ar_req.a     = {{(128-SW){1'b0}}, ax};
        ar_req.b     = {{(64-SW){1'b0}}, ax};
        ret_d        = S_WADD;
        st_d         = S_WAIT;
      end
      S_WADD: begin
        s2_d = s2_q + ar_res;
        if ({1'b0, cnt_q} == cfg.npix - NW'(1)) begin
          st_d = S_WEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
          st_d  = S_WRD;
        end
      end
      S_WEND: begin
        if (mx_q == mn_q) begin
          res_d.status = iasc_pkg::ST_BLANK;
          st_d         = S_EMIT;
        end else begin
          ar_req.start = 1'b1;
          ar_req.op    = iasc_pkg::OP_DIV;
          ar_req.a     = {64'd0, as1};
          ar_req.b     = {{(64-NW){1'b0}}, cfg.npix};
          ret_d        = S_MEAN;
          st_d         = S_WAIT;
        end
      end
      S_MEAN: begin
        mean_d = s1_q[63] ? (~ar_res[63:0] + 64'd1) : ar_res[63:0];
        if (cfg.npix < NW'(2)) begin
          st_d = S_OFF1;
        end else begin
          ar_req.start = 1'b1;
          ar_req.op    = iasc_pkg::OP_MUL;
          ar_req.a     = {64'd0, as1};
          ar_req.b     = as1;
          ret_d        = S_D1;
          st_d         = S_WAIT;
        end
      end
      S_D1: begin
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_DIV;
        ar_req.a     = ar_res;
        ar_req.b     = {{(64-NW){1'b0}}, cfg.npix};
        ret_d        = S_D2;
        st_d         = S_WAIT;
      end
      S_D2: begin
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_DIV;
        ar_req.a     = s2_q - ar_res;
        ar_req.b     = {{(64-NW){1'b0}}, cfg.npix - NW'(1)};
        ret_d        = S_SQRT;
        st_d         = S_WAIT;
      end
      S_SQRT: begin
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_SQRT;
        ar_req.a     = ar_res;
        ret_d        = S_OFF1;
        st_d         = S_WAIT;
      end
      // Clip offsets: (sigma >> 8) * k plus the rounded-down fraction part.
      S_OFF1: begin
        sigma_d      = sig;
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_MUL;
        ar_req.a     = {72'd0, sig[63:8]};
        ar_req.b     = {48'd0, cfg.upper_k};
        ret_d        = S_OFF2;
        st_d         = S_WAIT;
      end
      S_OFF2: begin
        p_d          = ar_res[63:0];
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_MUL;
        ar_req.a     = {120'd0, sigma_q[7:0]};
        ar_req.b     = {48'd0, cfg.upper_k};
        ret_d        = S_OFF3;
        st_d         = S_WAIT;
      end
      S_OFF3: begin
        offu_d       = sat_off(p_q, ar_res[63:0]);
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_MUL;
        ar_req.a     = {72'd0, sigma_q[63:8]};
        ar_req.b     = {48'd0, cfg.lower_k};
        ret_d        = S_OFF4;
        st_d         = S_WAIT;
      end
      S_OFF4: begin
        p_d          = ar_res[63:0];
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_MUL;
        ar_req.a     = {120'd0, sigma_q[7:0]};
        ar_req.b     = {48'd0, cfg.lower_k};
        ret_d        = S_OFFL;
        st_d         = S_WAIT;
      end
      S_OFFL: begin
        offl_d = sat_off(p_q, ar_res[63:0]);
        st_d   = S_CLIP;
      end
      S_CLIP: begin
        clip_hi_d = (mx64 < hi64) ? mx_q : hi64[SW-1:0];
        clip_lo_d = (mn64 > lo64) ? mn_q : lo64[SW-1:0];
        st_d      = S_SPAN;
      end
      S_SPAN: begin
        span_d       = {clip_hi_q[SW-1], clip_hi_q} - {clip_lo_q[SW-1], clip_lo_q};
        steps_d      = cfg.steps;
        rdy_d        = 1'b1;
        res_d.status = iasc_pkg::ST_OK;
        st_d         = S_EMIT;
      end
      // Read path: average by division through the image count, then the display code.
      S_RCLIP: begin
        b_d          = bcl;
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_DIV;
        ar_req.a     = {{(128-SW){1'b0}}, abs_bcl};
        ar_req.b     = {48'd0, images_q};
        ret_d        = S_RAVG;
        st_d         = S_WAIT;
      end
      S_RAVG: begin
        res_d.avg = avg_sat;
        if ((span_q != '0) && (steps_q != 7'd0)) begin
          ar_req.start = 1'b1;
          ar_req.op    = iasc_pkg::OP_MUL;
          ar_req.a     = {{(127-SW){1'b0}}, dif};
          ar_req.b     = {57'd0, steps_q};
          ret_d        = S_RNUM;
          st_d         = S_WAIT;
        end else begin
          res_d.code = iasc_pkg::DISPLAY_TOP - steps_q;
          st_d       = S_EMIT;
        end
      end
      S_RNUM: begin
        // Rounded quotient: (2*d*steps + span) / (2*span).
        ar_req.start = 1'b1;
        ar_req.op    = iasc_pkg::OP_DIV;
        ar_req.a     = {64'd0, num64};
        ar_req.b     = {{(62-SW){1'b0}}, span_q, 1'b0};
        ret_d        = S_RCODE;
        st_d         = S_WAIT;
      end
      S_RCODE: begin
        res_d.code = iasc_pkg::DISPLAY_TOP - steps_q + ar_res[6:0];
        st_d       = S_EMIT;
      end
      S_WAIT: begin
        if (!ar_busy) begin
          st_d = ret_q;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d           = 1'b1;
          out_d.status        = res_q.status;
          out_d.average_value = res_q.avg;
          out_d.display_code  = res_q.code;
          out_d.image_count   = images_q;
          st_d                = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ret_q     <= S_IDLE;
      images_q  <= '0;
      rdy_q     <= 1'b0;
      out_vld_q <= 1'b0;
      clip_hi_q <= '0;
      clip_lo_q <= '0;
      steps_q   <= '0;
      span_q    <= '0;
    end else begin
      st_q      <= st_d;
      ret_q     <= ret_d;
      images_q  <= images_d;
      rdy_q     <= rdy_d;
      out_vld_q <= out_vld_d;
      clip_hi_q <= clip_hi_d;
      clip_lo_q <= clip_lo_d;
      steps_q   <= steps_d;
      span_q    <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    samp_q  <= samp_d;
    first_q <= first_d;
    mn_q    <= mn_d;
    mx_q    <= mx_d;
    b_q     <= b_d;
    s1_q    <= s1_d;
    s2_q    <= s2_d;
    mean_q  <= mean_d;
    sigma_q <= sigma_d;
    p_q     <= p_d;
    offu_q  <= offu_d;
    offl_q  <= offl_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for image_average_sigma_clip_scale_core: stacks of images are summed,
// statistics computed and pixels read back, every result checked against an in-bench predictor.
// Depends on iasc_pkg, iasc_stream_if and the block's RTL.
module tb_top;

  // Register beyond the end of the list; writes to it must be ignored.
  localparam int unsigned REG_UNUSED = 5;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned IDLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  iasc_stream_if #(.payload_t(iasc_pkg::in_item_t)) in_if ();
  iasc_stream_if #(.payload_t(iasc_pkg::out_item_t)) out_if ();

  image_average_sigma_clip_scale_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the block: the stack sums, clip window and scale, and the registers.
  logic signed [47:0] stack_sum [iasc_pkg::MAX_PIXELS];
  int unsigned images_summed;
  longint clip_top, clip_bottom, clip_span;
  int unsigned code_steps;
  bit stats_valid;
  int unsigned width_reg, height_reg, upper_k, lower_k, floor_reg;

  iasc_pkg::out_item_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;      // no gaps on either side while set
  int unsigned out_stall = 0;

  function automatic int unsigned pixels_in_image();
    int unsigned w, h;
    w = (width_reg < 1) ? 1 : (width_reg > 64 ? 64 : width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > 64 ? 64 : height_reg);
    return (w * h > iasc_pkg::MAX_PIXELS) ? iasc_pkg::MAX_PIXELS : w * h;
  endfunction

  function automatic longint unsigned clip_offset(longint unsigned sigma, int unsigned k);
    longint unsigned off;
    off = (sigma >> 8) * k + (((sigma & 64'd255) * k) >> 8);
    return (off > (64'd1 << 60)) ? (64'd1 << 60) : off;
  endfunction

  function automatic void clear_stack();
    foreach (stack_sum[i]) stack_sum[i] = '0;
    images_summed = 0;
    clip_top = 0;
    clip_bottom = 0;
    clip_span = 0;
    code_steps = 0;
    stats_valid = 1'b0;
  endfunction

  // Walks the stack for min, max, mean and sigma and sets up the clip window and scale.
  function automatic logic [1:0] derive_statistics();
    int unsigned n, fl;
    longint mn, mx, s1, mean, hi, lo, x;
    longint unsigned ax, as1, sigma, t;
    logic [127:0] s2, variance;
    stats_valid = 1'b0;
    if (images_summed == 0) return iasc_pkg::ST_NO_IMAGES;
    n = pixels_in_image();
    mn = stack_sum[0];
    mx = stack_sum[0];
    s1 = 0;
    s2 = '0;
    for (int unsigned i = 0; i < n; i++) begin
      x = stack_sum[i];
      ax = (x < 0) ? -x : x;
      if (x < mn) mn = x;
      if (x > mx) mx = x;
      s1 += x;
      s2 = s2 + 128'(ax) * 128'(ax);
    end
    if (mx == mn) return iasc_pkg::ST_BLANK;
    mean = s1 / longint'(n);
    as1 = (s1 < 0) ? -s1 : s1;
    sigma = 0;
    if (n >= 2) begin
      variance = (s2 - (128'(as1) * 128'(as1)) / 128'(n)) / 128'(n - 1);
      for (int b = 63; b >= 0; b--) begin
        t = sigma | (64'd1 << b);
        if (128'(t) * 128'(t) <= variance) sigma = t;
      end
    end
    hi = mean + longint'(clip_offset(sigma, upper_k));
    lo = mean - longint'(clip_offset(sigma, lower_k));
    clip_top = (mx < hi) ? mx : hi;
    clip_bottom = (mn > lo) ? mn : lo;
    fl = (floor_reg > iasc_pkg::DISPLAY_TOP) ? iasc_pkg::DISPLAY_TOP : floor_reg;
    code_steps = iasc_pkg::DISPLAY_TOP - fl;
    clip_span = clip_top - clip_bottom;
    stats_valid = 1'b1;
    return iasc_pkg::ST_OK;
  endfunction

  // Applies one accepted item to the shadow state; returns 1 with the expected result if any.
  function automatic bit predict_result(iasc_pkg::in_item_t it, output iasc_pkg::out_item_t res);
    longint v, b, avg;
    longint unsigned num, span;
    int unsigned code;
    res = '0;
    case (it.action)
      iasc_pkg::ACT_RESTART: begin
        clear_stack();
        return 1'b0;
      end
      iasc_pkg::ACT_ACCUM: begin
        stats_valid = 1'b0;
        if (it.pixel_index < pixels_in_image()) begin
          v = (images_summed == 0) ? longint'(it.sample)
                                   : longint'(stack_sum[it.pixel_index]) + longint'(it.sample);
          if (v > SUM_HI) v = SUM_HI;
          if (v < SUM_LO) v = SUM_LO;
          stack_sum[it.pixel_index] = v[47:0];
        end
        if (it.end_of_image && images_summed < 65535) images_summed++;
        return 1'b0;
      end
      iasc_pkg::ACT_COMPUTE: res.status = derive_statistics();
      default: begin
        if (!stats_valid) begin
          res.status = (images_summed == 0) ? iasc_pkg::ST_NO_IMAGES : iasc_pkg::ST_NOT_READY;
        end else if (it.pixel_index < pixels_in_image()) begin
          b = stack_sum[it.pixel_index];
          if (b > clip_top) b = clip_top;
          if (b < clip_bottom) b = clip_bottom;
          avg = b / longint'(images_summed);
          if (avg > 64'sd2147483647) avg = 64'sd2147483647;
          if (avg < -64'sd2147483648) avg = -64'sd2147483648;
          code = iasc_pkg::DISPLAY_TOP - code_steps;
          if (clip_span > 0 && code_steps > 0) begin
            span = clip_span;
            num = longint'(b - clip_bottom) * code_steps * 2 + span;
            code += int'(num / (2 * span));
          end
          res.average_value = avg[31:0];
          res.display_code = code[6:0];
        end
      end
    endcase
    res.image_count = images_summed[15:0];
    return 1'b1;
  endfunction

  // Most gaps are short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one item; returns with valid still high so back-to-back items need no extra edge.
  task automatic send_item(logic [1:0] action, int unsigned idx, logic [31:0] sample,
                           bit eoi);
    iasc_pkg::in_item_t it;
    iasc_pkg::out_item_t res;
    int unsigned gap;
    gap = pick_gap();
    it.action = action;
    it.pixel_index = idx[iasc_pkg::IDX_W-1:0];
    it.sample = sample;
    it.end_of_image = eoi;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (predict_result(it, res)) pending_results.push_back(res);
    items_sent++;
  endtask

  // Waits until every result is back, then lets a pending accumulate finish.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_register(int unsigned index, int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(index * 4);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      iasc_pkg::REG_IMAGE_WIDTH:   width_reg = value & 32'h7F;
      iasc_pkg::REG_IMAGE_HEIGHT:  height_reg = value & 32'h7F;
      iasc_pkg::REG_UPPER_FACTOR:  upper_k = value & 32'hFFFF;
      iasc_pkg::REG_LOWER_FACTOR:  lower_k = value & 32'hFFFF;
      iasc_pkg::REG_DISPLAY_FLOOR: floor_reg = value & 32'h7F;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned up, int unsigned lo,
                           int unsigned fl);
    wait_idle();
    write_register(iasc_pkg::REG_IMAGE_WIDTH, w);
    write_register(iasc_pkg::REG_IMAGE_HEIGHT, h);
    write_register(iasc_pkg::REG_UPPER_FACTOR, up);
    write_register(iasc_pkg::REG_LOWER_FACTOR, lo);
    write_register(iasc_pkg::REG_DISPLAY_FLOOR, fl);
  endtask

  function automatic logic [31:0] pick_sample(bit full_range);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7FFF_FFFF;
    if (full_range || r < 20) return $urandom;
    return 32'(int'($urandom_range(0, 4000)) - 2000) << $urandom_range(4, 16);
  endfunction

  // Reads a few pixels, out-of-range positions among them.
  task automatic read_some(int unsigned count);
    int unsigned n;
    n = pixels_in_image();
    repeat (count)
      send_item(iasc_pkg::ACT_READ, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                    : $urandom_range(0, n - 1), $urandom, 0);
  endtask

  // One stack: restart, a first image that writes every entry with stray reads in between, further
  // partial images with stray computes in between, then the statistics and a few reads.
  task automatic run_stack(int unsigned image_total, bit full_range);
    int unsigned n, cnt, idx;
    n = pixels_in_image();
    send_item(iasc_pkg::ACT_RESTART, $urandom, $urandom, $urandom_range(0, 1));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(iasc_pkg::ACT_READ, $urandom, $urandom, 0);
      if ($urandom_range(0, 29) == 0)
        send_item(iasc_pkg::ACT_ACCUM, n + $urandom_range(0, 4095 - n), $urandom, 0);
      send_item(iasc_pkg::ACT_ACCUM, i, pick_sample(full_range), i == n - 1);
    end
    for (int unsigned img = 1; img < image_total; img++) begin
      cnt = $urandom_range(1, n + 2);
      for (int unsigned j = 0; j < cnt; j++) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, n - 1);
        if ($urandom_range(0, 24) == 0)
          send_item(iasc_pkg::ACT_COMPUTE, $urandom, $urandom, 0);
        send_item(iasc_pkg::ACT_ACCUM, idx, pick_sample(full_range), j == cnt - 1);
      end
    end
    send_item(iasc_pkg::ACT_COMPUTE, $urandom, $urandom, $urandom_range(0, 1));
    read_some((n < 12) ? n + 1 : 12);
    if ($urandom_range(0, 2) == 0) begin
      // Accumulating after the statistics makes them stale again.
      send_item(iasc_pkg::ACT_ACCUM, $urandom_range(0, n - 1), pick_sample(full_range), 0);
      read_some(2);
      send_item(iasc_pkg::ACT_COMPUTE, $urandom, $urandom, 0);
      read_some(3);
    end
  endtask

  // Extremes of the samples, reads and computes with nothing summed, a blank stack.
  task automatic test_directed();
    send_item(iasc_pkg::ACT_READ, 0, 0, 0);
    send_item(iasc_pkg::ACT_COMPUTE, 0, 0, 0);
    configure(2, 2, 768, 768, 0);
    send_item(iasc_pkg::ACT_RESTART, 0, 0, 0);
    send_item(iasc_pkg::ACT_ACCUM, 0, 32'h8000_0000, 0);
    send_item(iasc_pkg::ACT_ACCUM, 1, 32'h7FFF_FFFF, 0);
    send_item(iasc_pkg::ACT_ACCUM, 2, 32'h0000_0000, 0);
    send_item(iasc_pkg::ACT_ACCUM, 3, 32'hFFFF_FFFF, 1);
    send_item(iasc_pkg::ACT_READ, 1, 0, 0);
    send_item(iasc_pkg::ACT_ACCUM, 4095, 32'h1234_5678, 1);
    send_item(iasc_pkg::ACT_COMPUTE, 4095, 0, 0);
    for (int unsigned i = 0; i < 4; i++) send_item(iasc_pkg::ACT_READ, i, 0, 0);
    send_item(iasc_pkg::ACT_READ, 4, 0, 0);
    send_item(iasc_pkg::ACT_READ, 4095, 0, 0);
    send_item(iasc_pkg::ACT_RESTART, 4095, 32'hFFFF_FFFF, 1);
    for (int unsigned i = 0; i < 4; i++)
      send_item(iasc_pkg::ACT_ACCUM, i, 32'h0001_0000, i == 3);
    send_item(iasc_pkg::ACT_COMPUTE, 0, 0, 0);
    send_item(iasc_pkg::ACT_READ, 0, 0, 0);
  endtask

  // Register extremes: clamped sizes, zero and full sigma factors, every floor corner.
  task automatic test_registers();
    configure(0, 0, 768, 768, 0);
    run_stack(3, 1);
    configure(127, 1, 0, 0, 64);
    run_stack(2, 0);
    configure(5, 3, 65535, 65535, 126);
    run_stack(3, 1);
    configure(4, 4, 65535, 0, 127);
    run_stack(2, 0);
    configure(3, 7, 0, 65535, 0);
    run_stack(4, 0);
    wait_idle();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    run_stack(2, 1);
  endtask

  // Full-width rows and clamped tall columns.
  task automatic test_full_size();
    configure(64, 2, 512, 1024, 10);
    run_stack(2, 1);
    configure(0, 127, 300, 300, 0);
    run_stack(2, 0);
  endtask

  task automatic test_random();
    int unsigned start, w, h, up, lo;
    start = items_sent;
    while (items_sent - start < 400) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 16 : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      up = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
      lo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
      configure(w, h, up, lo, $urandom_range(0, 127));
      quiet = ($urandom_range(0, 3) == 0);
      run_stack($urandom_range(1, 5), $urandom_range(0, 1));
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls, with quiet stretches of none.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_if.ready <= 1'b1;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      out_stall <= pick_gap();
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    iasc_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d average %0d code %0d count %0d",
               out_if.payload.status, out_if.payload.average_value,
               out_if.payload.display_code, out_if.payload.image_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.payload.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.payload.status);
          error_count++;
        end
        if (out_if.payload.average_value !== want.average_value) begin
          $error("average_value: expected %0d, got %0d", want.average_value,
                 out_if.payload.average_value);
          error_count++;
        end
        if (out_if.payload.display_code !== want.display_code) begin
          $error("display_code: expected %0d, got %0d", want.display_code,
                 out_if.payload.display_code);
          error_count++;
        end
        if (out_if.payload.image_count !== want.image_count) begin
          $error("image_count: expected %0d, got %0d", want.image_count,
                 out_if.payload.image_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    clear_stack();
    width_reg = 64;
    height_reg = 64;
    upper_k = 768;
    lower_k = 768;
    floor_reg = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_registers();
    test_full_size();
    test_random();
    wait_idle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/iasc_pkg.sv
src/iasc_stream_if.sv
src/iasc_arith.sv
src/iasc_cfg.sv
src/image_average_sigma_clip_scale_core.sv
tb/sv/tb_top.sv
